@@ design/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants for the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int ERR_W    = 9;
    localparam int SUM_W    = 10;
    localparam int DIF_W    = 10;
    localparam int GAIN_W   = 16;
    localparam int LIM_W    = 9;
    localparam int DRIVE_W  = 8;

    // Datapath widths
    localparam int PP_W     = GAIN_W + ERR_W;
    localparam int PI_W     = GAIN_W + SUM_W;
    localparam int PD_W     = GAIN_W + DIF_W;
    localparam int ACC_W    = 28;
    localparam int RAW_W    = SUM_W + 1;
    localparam int FRAC_W   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 8'd254;

    localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST = 16'sd256;
    localparam logic signed [GAIN_W-1:0] GAIN_INT_RST  = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_DER_RST  = 16'sd0;
    localparam logic [LIM_W-1:0]         SUM_LIM_RST   = 9'd200;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP     = 2'd0,
        CFG_GAIN_INTEGRAL = 2'd1,
        CFG_GAIN_DERIV    = 2'd2,
        CFG_SUM_LIMIT     = 2'd3
    } t_cfg_idx;

    // Live configuration
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_prop;
        logic signed [GAIN_W-1:0] gain_integral;
        logic signed [GAIN_W-1:0] gain_deriv;
        logic [LIM_W-1:0]         sum_limit;
    } t_cfg;

endpackage

@@ design/pidc_in_if.sv @@
// ----------------------------------------------------------------------------
// pidc_in_if
// Sample channel: setpoint and measured value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pidc_in_if
    import pidc_pkg::*;
;
    logic                ready;
    logic                valid;
    logic [SAMPLE_W-1:0] setpoint;
    logic [SAMPLE_W-1:0] measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

@@ design/pidc_out_if.sv @@
// ----------------------------------------------------------------------------
// pidc_out_if
// Result channel: drive value, error and clamped sum with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pidc_out_if
    import pidc_pkg::*;
;
    logic                     ready;
    logic                     valid;
    logic [DRIVE_W-1:0]       drive;
    logic signed [ERR_W-1:0]  error_now;
    logic signed [SUM_W-1:0]  sum_now;

    modport source (output valid, output drive, output error_now, output sum_now,
                    input ready);
    modport sink   (input valid, input drive, input error_now, input sum_now,
                    output ready);
endinterface

@@ design/pidc_cfg.sv @@
// ----------------------------------------------------------------------------
// pidc_cfg
// Configuration registers: gains and sum limit, written by index.
// ----------------------------------------------------------------------------
module pidc_cfg
    import pidc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write into the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_PROP:     n_cfg.gain_prop     = i_cfg_data;
                CFG_GAIN_INTEGRAL: n_cfg.gain_integral = i_cfg_data;
                CFG_GAIN_DERIV:    n_cfg.gain_deriv    = i_cfg_data;
                CFG_SUM_LIMIT:     n_cfg.sum_limit     = i_cfg_data[LIM_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop     <= GAIN_PROP_RST;
            r_cfg.gain_integral <= GAIN_INT_RST;
            r_cfg.gain_deriv    <= GAIN_DER_RST;
            r_cfg.sum_limit     <= SUM_LIM_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/pid_controller_clamped.sv @@
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Discrete PID controller with clamped error sum and clamped drive output.
//
//   Channel   Dir  Handshake          Beat contents
//   i_pid     in   valid / ready      setpoint, measured
//   o_pid     out  valid / ready      drive, error_now, sum_now
//   cfg       in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// Three-stage pipeline: error and clamped sum, three gain products, sum and
// drive clamp. One beat per cycle is accepted while the result side keeps up.
// The error sum and previous error updates in the first stage are the only
// loops; both are registered in the cycle the beat is taken.
// Synchronous active-low reset clears valids, the sum, the previous error and
// loads the default gains and limit. A stall on o_pid fills stages back to front.
// ----------------------------------------------------------------------------
module pid_controller_clamped
    import pidc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pidc_in_if.sink               i_pid,
    pidc_out_if.source            o_pid,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg w_cfg;

    pidc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Controller state
    logic signed [ERR_W-1:0] r_prev_err;
    logic signed [SUM_W-1:0] r_err_sum;

    // Stage valids
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_acc1, w_ld2, w_ld3;

    // Stage 1 payload
    logic signed [ERR_W-1:0] r1_err;
    logic signed [SUM_W-1:0] r1_sum;
    logic signed [DIF_W-1:0] r1_dif;

    // Stage 2 payload
    logic signed [PP_W-1:0]  r2_pp;
    logic signed [PI_W-1:0]  r2_pi;
    logic signed [PD_W-1:0]  r2_pd;
    logic signed [ERR_W-1:0] r2_err;
    logic signed [SUM_W-1:0] r2_sum;

    // Stage 3 payload
    logic [DRIVE_W-1:0]      r3_drive;
    logic signed [ERR_W-1:0] r3_err;
    logic signed [SUM_W-1:0] r3_sum;

    // Next values
    logic signed [ERR_W-1:0] n_err;
    logic signed [RAW_W-1:0] n_raw;
    logic signed [RAW_W-1:0] n_lim;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [DIF_W-1:0] n_dif;
    logic signed [PP_W-1:0]  n_pp;
    logic signed [PI_W-1:0]  n_pi;
    logic signed [PD_W-1:0]  n_pd;
    logic signed [ACC_W-1:0] n_acc;
    logic [DRIVE_W-1:0]      n_drive;

    // Flow control: each stage loads when empty or when its contents move on
    assign w_rdy3 = !r_v3 || o_pid.ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_ld3  = r_v2 && w_rdy3;
    assign w_ld2  = r_v1 && w_rdy2;
    assign w_acc1 = i_pid.valid && w_rdy1;

    assign i_pid.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_pid.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: error, clamped sum, error difference
    always_comb begin
        n_err = $signed({1'b0, i_pid.setpoint}) - $signed({1'b0, i_pid.measured});
        n_raw = RAW_W'(r_err_sum) + RAW_W'(n_err);
        n_lim = $signed({2'b00, w_cfg.sum_limit});
        if (n_raw < -n_lim) begin
            n_sum = SUM_W'(-n_lim);
        end else if (n_raw > n_lim) begin
            n_sum = SUM_W'(n_lim);
        end else begin
            n_sum = SUM_W'(n_raw);
        end
        n_dif = DIF_W'(n_err) - DIF_W'(r_prev_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_err_sum  <= '0;
        end else if (w_acc1) begin
            r_prev_err <= n_err;
            r_err_sum  <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc1) begin
            r1_err <= n_err;
            r1_sum <= n_sum;
            r1_dif <= n_dif;
        end
    end

    // Stage 2: gain products
    assign n_pp = PP_W'(w_cfg.gain_prop) * PP_W'(r1_err);
    assign n_pi = PI_W'(w_cfg.gain_integral) * PI_W'(r1_sum);
    assign n_pd = PD_W'(w_cfg.gain_deriv) * PD_W'(r1_dif);

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r2_pp  <= n_pp;
            r2_pi  <= n_pi;
            r2_pd  <= n_pd;
            r2_err <= r1_err;
            r2_sum <= r1_sum;
        end
    end

    // Stage 3: add products, drop fraction, clamp to drive range
    always_comb begin
        n_acc = ACC_W'(r2_pp) + ACC_W'(r2_pi) + ACC_W'(r2_pd);
        if (n_acc[ACC_W-1]) begin
            n_drive = '0;
        end else if (n_acc[ACC_W-2:FRAC_W] > (ACC_W-1-FRAC_W)'(DRIVE_MAX)) begin
            n_drive = DRIVE_MAX;
        end else begin
            n_drive = n_acc[FRAC_W+DRIVE_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r3_drive <= n_drive;
            r3_err   <= r2_err;
            r3_sum   <= r2_sum;
        end
    end

    assign o_pid.valid     = r_v3;
    assign o_pid.drive     = r3_drive;
    assign o_pid.error_now = r3_err;
    assign o_pid.sum_now   = r3_sum;

`ifndef NO_ASSERTIONS
    // Drive never leaves its clamp range
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r3_drive <= DRIVE_MAX))
        else $error("drive above clamp");

    // Newest stage-1 beat matches the stored previous error
    a_prev_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r1_err == r_prev_err))
        else $error("previous error out of step with stage 1");

    // Newest stage-1 beat matches the stored error sum
    a_sum_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r1_sum == r_err_sum))
        else $error("error sum out of step with stage 1");
`endif

endmodule

@@ tb/sv/pid_controller_clamped_tb.sv @@
// ----------------------------------------------------------------------------
// pid_controller_clamped_tb
// Self-checking bench for the clamped PID controller. A predictor in the bench
// tracks the gains, the sum limit, the previous error and the clamped error
// sum. It computes drive, error and sum for every sample beat taken. A checker
// matches each result beat against the oldest prediction. Directed samples hit
// the field extremes, drive saturation, the zero and the widest sum limits, a
// limit written with stray upper bits, and the gain extremes. Random streams
// follow under changing settings and four mixes of sender idling and receiver
// stalls.
// ----------------------------------------------------------------------------
module pid_controller_clamped_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [DRIVE_W-1:0]      drive;
        logic signed [ERR_W-1:0] error_now;
        logic signed [SUM_W-1:0] sum_now;
    } t_pid_beat;

    typedef enum int {SEQ_UNIFORM, SEQ_STEP, SEQ_BIASED} t_seq_style;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pidc_in_if  pid_in();
    pidc_out_if pid_out();

    pid_controller_clamped DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pid      (pid_in),
        .o_pid      (pid_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: live settings plus the controller memory
    t_cfg                    live_cfg;
    logic signed [ERR_W-1:0] prev_error;
    logic signed [SUM_W-1:0] error_sum;

    t_pid_beat pending_beats[$];
    t_pid_beat want;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int n_errors   = 0;
    int n_checked  = 0;
    int n_samples  = 0;
    int n_settings = 0;
    int cycles     = 0;

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%t: run exceeded %0d cycles", $realtime, CYCLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: stall at random with the current stall rate
    always @(posedge i_clk) begin
        pid_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compute the expected result of one sample and advance the controller memory
    function automatic t_pid_beat pid_step(input logic [SAMPLE_W-1:0] sp,
                                           input logic [SAMPLE_W-1:0] mv);
        int e, s, lim, pe, ps, acc, kp, ki, kd, drv;
        t_pid_beat r;
        e   = int'(sp) - int'(mv);
        pe  = prev_error;
        ps  = error_sum;
        lim = int'(live_cfg.sum_limit);
        kp  = $signed(live_cfg.gain_prop);
        ki  = $signed(live_cfg.gain_integral);
        kd  = $signed(live_cfg.gain_deriv);
        s   = ps + e;
        if (s < -lim) s = -lim;
        if (s > lim) s = lim;
        acc = kp * e + ki * s + kd * (e - pe);
        if (acc < 0) begin
            drv = 0;
        end else begin
            drv = acc >>> FRAC_W;
            if (drv > int'(DRIVE_MAX)) drv = int'(DRIVE_MAX);
        end
        prev_error  = ERR_W'(e);
        error_sum   = SUM_W'(s);
        r.drive     = DRIVE_W'(drv);
        r.error_now = ERR_W'(e);
        r.sum_now   = SUM_W'(s);
        return r;
    endfunction

    // Checker: match each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && pid_out.valid && pid_out.ready) begin
            if (pending_beats.size() == 0) begin
                $display("%t: result beat with nothing expected: drive %0d error %0d sum %0d",
                         $realtime, pid_out.drive, pid_out.error_now, pid_out.sum_now);
                n_errors++;
            end else begin
                want = pending_beats.pop_front();
                n_checked++;
                if (pid_out.drive !== want.drive) begin
                    $display("%t: drive expected %0d actual %0d",
                             $realtime, want.drive, pid_out.drive);
                    n_errors++;
                end
                if (pid_out.error_now !== want.error_now) begin
                    $display("%t: error_now expected %0d actual %0d",
                             $realtime, want.error_now, pid_out.error_now);
                    n_errors++;
                end
                if (pid_out.sum_now !== want.sum_now) begin
                    $display("%t: sum_now expected %0d actual %0d",
                             $realtime, want.sum_now, pid_out.sum_now);
                    n_errors++;
                end
            end
        end
    end

    // Send one sample beat; idle first at the current idle rate
    task automatic send_sample(input logic [SAMPLE_W-1:0] sp, input logic [SAMPLE_W-1:0] mv);
        while ($urandom_range(99) < idle_pct) begin
            pid_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pid_in.valid    <= 1'b1;
        pid_in.setpoint <= sp;
        pid_in.measured <= mv;
        do @(posedge i_clk); while (!pid_in.ready);
        pending_beats.push_back(pid_step(sp, mv));
        n_samples++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        pid_in.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; only called with the pipeline empty
    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_GAIN_PROP:     live_cfg.gain_prop     = value;
            CFG_GAIN_INTEGRAL: live_cfg.gain_integral = value;
            CFG_GAIN_DERIV:    live_cfg.gain_deriv    = value;
            CFG_SUM_LIMIT:     live_cfg.sum_limit     = value[LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                                 input logic [CFG_DATA_W-1:0] kd,
                                 input logic [CFG_DATA_W-1:0] lim);
        drain();
        write_register(CFG_GAIN_PROP, kp);
        write_register(CFG_GAIN_INTEGRAL, ki);
        write_register(CFG_GAIN_DERIV, kd);
        write_register(CFG_SUM_LIMIT, lim);
        n_settings++;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return '0;
                    default: return 16'h0100;
                endcase
            end
            1:       return GAIN_W'($urandom_range(1023));
            2:       return GAIN_W'($urandom_range(2048) - 1024);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        case ($urandom_range(3))
            0:       return CFG_DATA_W'($urandom_range(511));
            1:       return CFG_DATA_W'($urandom);
            2:       return $urandom_range(1) ? CFG_DATA_W'(511) : '0;
            default: return CFG_DATA_W'($urandom_range(40));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] clip8(input int v);
        if (v < 0) return '0;
        if (v > 255) return 8'd255;
        return SAMPLE_W'(v);
    endfunction

    // Reset gains: unity proportional, limit 200; sweep the field extremes
    task automatic test_default_gains();
        send_sample(8'd0, 8'd0);
        send_sample(8'd255, 8'd0);
        send_sample(8'd0, 8'd255);
        send_sample(8'd255, 8'd255);
        send_sample(8'd200, 8'd10);
        send_sample(8'd10, 8'd200);
    endtask

    // Zero limit holds the sum at zero whatever the error
    task automatic test_zero_limit();
        load_settings(16'h0100, 16'h0100, 16'h0000, 16'h0000);
        send_sample(8'd255, 8'd0);
        send_sample(8'd0, 8'd255);
    endtask

    // Limit written with upper bits set: only the low nine bits count
    task automatic test_wide_limit();
        load_settings(16'h0000, 16'h0100, 16'h0000, 16'hFFFF);
        repeat (3) send_sample(8'd255, 8'd0);
        drain();
        write_register(CFG_SUM_LIMIT, 16'hFE05);
        send_sample(8'd0, 8'd255);
    endtask

    // Largest and most negative proportional and derivative gain; most negative integral gain
    task automatic test_gain_extremes();
        load_settings(16'h7FFF, 16'h0000, 16'h0000, 16'd200);
        send_sample(8'd255, 8'd0);
        drain();
        write_register(CFG_GAIN_PROP, 16'h8000);
        send_sample(8'd0, 8'd255);
        send_sample(8'd1, 8'd0);
        load_settings(16'h0000, 16'h0000, 16'h7FFF, 16'd511);
        send_sample(8'd0, 8'd255);
        send_sample(8'd255, 8'd0);
        load_settings(16'h0000, 16'h8000, 16'h8000, 16'd511);
        send_sample(8'd0, 8'd255);
        send_sample(8'd0, 8'd200);
    endtask

    // Random streams in chunks, each chunk under fresh settings
    task automatic test_random_phase(input int count, input int idle, input int stall);
        int sent, chunk, target, level, offset;
        t_seq_style style;
        logic [SAMPLE_W-1:0] sp, mv;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < count) begin
            load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit());
            style  = t_seq_style'($urandom_range(2));
            chunk  = $urandom_range(20, 60);
            target = $urandom_range(255);
            level  = $urandom_range(255);
            offset = $urandom_range(1, 80);
            for (int k = 0; k < chunk && sent < count; k++) begin
                case (style)
                    SEQ_STEP: begin
                        // hold the setpoint, let the measurement settle toward it
                        level = level + (target - level) / 4 + int'($urandom_range(6)) - 3;
                        sp = SAMPLE_W'(target);
                        mv = clip8(level);
                    end
                    SEQ_BIASED: begin
                        // one-sided error that reverses halfway to unwind the sum
                        level = $urandom_range(255);
                        if (k == chunk / 2) offset = -offset;
                        sp = clip8(level + offset);
                        mv = SAMPLE_W'(level);
                    end
                    default: begin
                        sp = SAMPLE_W'($urandom);
                        mv = SAMPLE_W'($urandom);
                    end
                endcase
                send_sample(sp, mv);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        pid_in.valid    = 1'b0;
        pid_in.setpoint = '0;
        pid_in.measured = '0;

        live_cfg.gain_prop     = GAIN_PROP_RST;
        live_cfg.gain_integral = GAIN_INT_RST;
        live_cfg.gain_deriv    = GAIN_DER_RST;
        live_cfg.sum_limit     = SUM_LIM_RST;
        prev_error             = '0;
        error_sum              = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_gains();
        test_zero_limit();
        test_wide_limit();
        test_gain_extremes();
        test_random_phase(275, 0, 0);
        test_random_phase(275, 72, 0);
        test_random_phase(275, 0, 72);
        test_random_phase(275, 10, 10);

        idle_pct  = 0;
        stall_pct = 0;
        drain();
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results for %0d samples under %0d settings of gains and limit,",
                 n_checked, n_samples, n_settings);
        $display("with free flow, sender idling, receiver stalls and both; %0d mismatches.",
                 n_errors);
        if (n_errors == 0 && pending_beats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
